[src/indexed_list_append_delete_max_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list core
// Same-cycle and next-cycle implication checks on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_APPEND_DELETE_MAX_CORE_ASSERT_SVH
`define INDEXED_LIST_APPEND_DELETE_MAX_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define ILAD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ilad assertion failed");

// check cons in the cycle after ante
`define ILAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ilad assertion failed");

`endif

[src/ilad_pkg.sv]
// ----------------------------------------------------------------------------
// ilad_pkg
// Shared types and constants of the ordered list core.
// ----------------------------------------------------------------------------
package ilad_pkg;

  localparam int ILAD_CAPACITY    = 16;
  localparam int ILAD_OP_W        = 3;
  localparam int ILAD_VAL_W       = 31;
  localparam int ILAD_POS_W       = 4;
  localparam int ILAD_OUT_W       = 32;
  localparam int ILAD_QUEUE_DEPTH = 2;

  localparam logic signed [ILAD_OUT_W-1:0] ILAD_NONE_VALUE = -32'sd1;

  typedef enum logic [ILAD_OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_PRINT     = 3'd2,
    OP_PRINT_REV = 3'd3,
    OP_MAX       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e                   op;
    logic [ILAD_VAL_W-1:0] value;
    logic [ILAD_POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic signed [ILAD_OUT_W-1:0] value;
    status_e                      status;
    logic                         last;
  } res_t;

  typedef struct packed {
    logic idle;
    logic cmd_pop;
  } back_stat_t;

endpackage

[src/ilad_fifo.sv]
// ----------------------------------------------------------------------------
// ilad_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ilad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTRW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTRW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/ilad_front.sv]
// ----------------------------------------------------------------------------
// ilad_front
// Accepts items, drops unused op codes and queues commands for the back end.
// ----------------------------------------------------------------------------
module ilad_front
  import ilad_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [ILAD_OP_W-1:0]  op_i,
  input  logic [ILAD_VAL_W-1:0] new_value_i,
  input  logic [ILAD_POS_W-1:0] position_i,
  input  logic                  cmd_pop_i,
  output cmd_t                  cmd_o,
  output logic                  cmd_valid_o
);

  cmd_t cmd_in;
  logic op_legal;
  logic cmd_empty;

  assign op_legal = (op_i <= ILAD_OP_W'(OP_MAX));

  always_comb begin
    cmd_in.op       = op_e'(op_i);
    cmd_in.value    = new_value_i;
    cmd_in.position = position_i;
  end

  ilad_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (ILAD_QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && op_legal),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

[src/ilad_back.sv]
// ----------------------------------------------------------------------------
// ilad_back
// Runs list commands on an entry memory, one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
module ilad_back
  import ilad_pkg::*;
#(
  parameter int CAPACITY = ILAD_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  input  logic       res_full_i,
  output logic       res_push_o,
  output res_t       res_o,
  output back_stat_t stat_o
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (ILAD_POS_W > CNTW) ? ILAD_POS_W : CNTW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_LIST  = 7'b0000100,
    S_MAX   = 7'b0001000,
    S_DEL   = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [ILAD_VAL_W-1:0] mem_q [CAPACITY];
  logic [ILAD_VAL_W-1:0] rdata_q;
  logic [CNTW-1:0]       count_q, count_d;
  logic [CNTW-1:0]       cur_q, cur_d;
  logic [CNTW-1:0]       k_q, k_d;
  logic [CNTW-1:0]       cur_m1, count_m1;
  op_e                   op_q, op_d;
  logic [ILAD_POS_W-1:0] pos_q, pos_d;
  logic [ILAD_VAL_W-1:0] best_q, best_d, best_new;
  logic signed [ILAD_OUT_W-1:0] emit_val_q, emit_val_d;
  status_e               emit_st_q, emit_st_d;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [ILAD_VAL_W-1:0] wdata;
  logic                  cmd_pop;
  logic                  at_last;

  assign cur_m1   = cur_q - CNTW'(1);
  assign count_m1 = count_q - CNTW'(1);
  assign at_last  = (k_q == count_m1);
  assign best_new = (rdata_q > best_q) ? rdata_q : best_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cur_d      = cur_q;
    k_d        = k_q;
    op_d       = op_q;
    pos_d      = pos_q;
    best_d     = best_q;
    emit_val_d = emit_val_q;
    emit_st_d  = emit_st_q;
    we         = 1'b0;
    waddr      = count_q[IW-1:0];
    wdata      = cmd_i.value;
    cmd_pop    = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{value: {1'b0, rdata_q}, status: ST_OK, last: at_last};
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop   = 1'b1;
          op_d      = cmd_i.op;
          pos_d     = cmd_i.position;
          k_d       = '0;
          best_d    = '0;
          emit_val_d = ILAD_NONE_VALUE;
          emit_st_d  = ST_EMPTY;
          state_d    = S_LOAD;
          unique case (cmd_i.op)
            OP_APPEND: begin
              if (count_q == CNTW'(CAPACITY)) begin
                emit_st_d = ST_FULL;
                state_d   = S_EMIT;
              end else begin
                we      = 1'b1;
                count_d = count_q + CNTW'(1);
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                state_d = S_EMIT;
              end else if (CMPW'(cmd_i.position) >= CMPW'(count_q)) begin
                emit_st_d = ST_BAD_INDEX;
                state_d   = S_EMIT;
              end
            end
            default: begin
              if (count_q == '0) begin
                state_d = S_EMIT;
              end
            end
          endcase
        end
      end
      S_LOAD: begin
        unique case (op_q)
          OP_PRINT_REV: begin
            cur_d   = count_m1;
            state_d = S_LIST;
          end
          OP_DELETE: begin
            cur_d   = CNTW'(pos_q);
            state_d = S_DEL;
          end
          OP_MAX: begin
            cur_d   = '0;
            state_d = S_MAX;
          end
          default: begin
            cur_d   = '0;
            state_d = S_LIST;
          end
        endcase
      end
      S_LIST: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          k_d        = k_q + CNTW'(1);
          cur_d      = (op_q == OP_PRINT_REV) ? cur_m1 : cur_q + CNTW'(1);
          if (at_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_MAX: begin
        best_d = best_new;
        k_d    = k_q + CNTW'(1);
        cur_d  = cur_q + CNTW'(1);
        if (at_last) begin
          emit_val_d = {1'b0, best_new};
          emit_st_d  = ST_OK;
          state_d    = S_EMIT;
        end
      end
      S_DEL: begin
        emit_val_d = {1'b0, rdata_q};
        emit_st_d  = ST_OK;
        cur_d      = cur_q + CNTW'(1);
        state_d    = S_SHIFT;
      end
      S_SHIFT: begin
        if (cur_q < count_q) begin
          we    = 1'b1;
          waddr = cur_m1[IW-1:0];
          wdata = rdata_q;
          cur_d = cur_q + CNTW'(1);
        end else begin
          count_d = count_m1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        res_o = '{value: emit_val_q, status: emit_st_q, last: 1'b1};
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign stat_o = '{idle: (state_q == S_IDLE), cmd_pop: cmd_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    k_q        <= k_d;
    op_q       <= op_d;
    pos_q      <= pos_d;
    best_q     <= best_d;
    emit_val_q <= emit_val_d;
    emit_st_q  <= emit_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[cur_d[IW-1:0]];
  end

endmodule

[src/indexed_list_append_delete_max_core.sv]
// ----------------------------------------------------------------------------
// indexed_list_append_delete_max_core
// Bounded ordered list with append, delete by index, print, reverse print and
// max, behind queue-style command and result ports.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue and are carried out one at a time by
// a sequencer that walks a dual-port entry memory, one entry per cycle while
// the result side is not stalled. With n values held, append gives n + 1
// results, both prints give n results, max and delete give one result each,
// and any error or empty case gives one result. Unused op codes are dropped
// on entry and give no result. Results pass through a two-entry queue; a
// stalled result side halts the walk without losing data.
// ----------------------------------------------------------------------------
`include "indexed_list_append_delete_max_core_assert.svh"

module indexed_list_append_delete_max_core
  import ilad_pkg::*;
#(
  parameter int CAPACITY = ILAD_CAPACITY
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [ILAD_OP_W-1:0]         op_i,
  input  logic [ILAD_VAL_W-1:0]        new_value_i,
  input  logic [ILAD_POS_W-1:0]        position_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [ILAD_OUT_W-1:0] out_value_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  cmd_t       cmd;
  logic       cmd_valid;
  logic       res_full;
  logic       res_push;
  res_t       res;
  res_t       res_out;
  back_stat_t stat;

  ilad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .op_i        (op_i),
    .new_value_i (new_value_i),
    .position_i  (position_i),
    .cmd_pop_i   (stat.cmd_pop),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  ilad_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .stat_o      (stat)
  );

  ilad_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (ILAD_QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_value_o = res_out.value;
  assign status_o    = res_out.status;
  assign last_o      = res_out.last;

  `ILAD_ASSERT_NEXT(a_last_then_idle, res_push && res.last, stat.idle)
  `ILAD_ASSERT_IMPL(a_push_has_room, res_push, !res_full)
  `ILAD_ASSERT_IMPL(a_pop_has_cmd, stat.cmd_pop, cmd_valid && stat.idle)

endmodule

[dv/ilad_list_monitor.sv]
// ----------------------------------------------------------------------------
// ilad_list_monitor
// Watches both queue ports of the ordered list core, keeps its own copy of
// the list, predicts the results of every accepted item and compares each
// popped result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ilad_list_monitor
  import ilad_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [ILAD_OP_W-1:0]         op_i,
  input  logic [ILAD_VAL_W-1:0]        new_value_i,
  input  logic [ILAD_POS_W-1:0]        position_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic signed [ILAD_OUT_W-1:0] out_value_i,
  input  logic [1:0]                   status_i,
  input  logic                         last_i,
  output int                           fail_cnt_o,
  output int                           pending_o
);

  logic [ILAD_VAL_W-1:0] list_vals [ILAD_CAPACITY];
  int unsigned           list_len;
  res_t                  expected_results [$];
  res_t                  oldest;

  function automatic void queue_result(logic signed [ILAD_OUT_W-1:0] value, status_e status,
                                       logic last);
    res_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  function automatic void queue_listing(bit reverse);
    int unsigned idx;
    for (int unsigned i = 0; i < list_len; i++) begin
      idx = reverse ? (list_len - 1 - i) : i;
      queue_result({1'b0, list_vals[idx]}, ST_OK, (i + 1 == list_len));
    end
  endfunction

  function automatic void apply_list_op(logic [ILAD_OP_W-1:0] op, logic [ILAD_VAL_W-1:0] value,
                                        logic [ILAD_POS_W-1:0] pos);
    logic [ILAD_VAL_W-1:0] removed;
    logic [ILAD_VAL_W-1:0] best;
    case (op)
      OP_APPEND: begin
        if (list_len >= ILAD_CAPACITY) begin
          queue_result(ILAD_NONE_VALUE, ST_FULL, 1'b1);
        end else begin
          list_vals[list_len] = value;
          list_len++;
          queue_listing(1'b0);
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          queue_result(ILAD_NONE_VALUE, ST_EMPTY, 1'b1);
        end else if (pos >= list_len) begin
          queue_result(ILAD_NONE_VALUE, ST_BAD_INDEX, 1'b1);
        end else begin
          removed = list_vals[pos];
          for (int unsigned i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
          queue_result({1'b0, removed}, ST_OK, 1'b1);
        end
      end
      OP_PRINT, OP_PRINT_REV: begin
        if (list_len == 0) begin
          queue_result(ILAD_NONE_VALUE, ST_EMPTY, 1'b1);
        end else begin
          queue_listing(op == OP_PRINT_REV);
        end
      end
      OP_MAX: begin
        if (list_len == 0) begin
          queue_result(ILAD_NONE_VALUE, ST_EMPTY, 1'b1);
        end else begin
          best = '0;
          for (int unsigned i = 0; i < list_len; i++) if (list_vals[i] > best) best = list_vals[i];
          queue_result({1'b0, best}, ST_OK, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
      fail_cnt_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_value %0d status %0d last %0d",
                 out_value_i, status_i, last_i);
          fail_cnt_o++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_value_i !== oldest.value) begin
            $error("out_value mismatch: expected %0d, actual %0d", oldest.value, out_value_i);
            fail_cnt_o++;
          end
          if (status_i !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, status_i);
            fail_cnt_o++;
          end
          if (last_i !== oldest.last) begin
            $error("last mismatch: expected %0d, actual %0d", oldest.last, last_i);
            fail_cnt_o++;
          end
        end
      end
      if (push_i && !full_i) apply_list_op(op_i, new_value_i, position_i);
    end
    pending_o = expected_results.size();
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the ordered list core with directed edge cases and random phases of
// fill, drain and mixed items, with random gaps on both ports, one long
// result-side stall and full drains; the monitor predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ilad_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 370;
  localparam int PHASE_ITEMS    = 30;
  localparam int DRAIN_CYCLES   = 40;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         push;
  logic                         full;
  logic [ILAD_OP_W-1:0]         op_i;
  logic [ILAD_VAL_W-1:0]        new_value_i;
  logic [ILAD_POS_W-1:0]        position_i;
  logic                         empty;
  logic                         pop;
  logic signed [ILAD_OUT_W-1:0] out_value_o;
  logic [1:0]                   status_o;
  logic                         last_o;
  int                           fail_cnt;
  int                           pending_cnt;
  int                           cycle_cnt;
  bit                           calm;
  bit                           rx_hold_req;
  int                           rx_idle;

  indexed_list_append_delete_max_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .new_value_i (new_value_i),
    .position_i  (position_i),
    .empty       (empty),
    .pop         (pop),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  ilad_list_monitor i_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .op_i        (op_i),
    .new_value_i (new_value_i),
    .position_i  (position_i),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_value_i (out_value_o),
    .status_i    (status_o),
    .last_i      (last_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i) cycle_cnt++;
    $display("Some tests failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random gaps, one long hold on request
  initial begin
    pop = 1'b0;
    rx_idle = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        pop = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_idle > 0) begin
        pop = 1'b0;
        rx_idle--;
      end else begin
        pop = rst_ni;
        if ($urandom_range(0, 3) == 0) rx_idle = idle_len();
      end
    end
  end

  // call at a falling edge; returns at a falling edge
  task automatic send_item(logic [ILAD_OP_W-1:0] op, logic [ILAD_VAL_W-1:0] value,
                           logic [ILAD_POS_W-1:0] pos);
    int gap;
    op_i        = op;
    new_value_i = value;
    position_i  = pos;
    push        = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    push = 1'b0;
    wait (pending_cnt == 0);
    @(negedge clk_i);
  endtask

  // mode 0 fills the list, mode 1 drains it, mode 2 mixes
  task automatic send_random_item(int mode, inout int counted);
    int                    r;
    int                    v;
    logic [ILAD_OP_W-1:0]  op;
    logic [ILAD_VAL_W-1:0] value;
    logic [ILAD_POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      op = ILAD_OP_W'($urandom_range(OP_MAX + 1, 2 ** ILAD_OP_W - 1));
    end else begin
      r = $urandom_range(0, 99);
      case (mode)
        0:       op = ILAD_OP_W'((r < 65) ? OP_APPEND : (r < 75) ? OP_DELETE :
                                 $urandom_range(OP_PRINT, OP_MAX));
        1:       op = ILAD_OP_W'((r < 15) ? OP_APPEND : (r < 65) ? OP_DELETE :
                                 $urandom_range(OP_PRINT, OP_MAX));
        default: op = ILAD_OP_W'($urandom_range(OP_APPEND, OP_MAX));
      endcase
    end
    v = $urandom_range(0, 99);
    if (v < 15)      value = ILAD_VAL_W'($urandom_range(0, 7));
    else if (v < 22) value = {ILAD_VAL_W{1'b1}};
    else if (v < 27) value = '0;
    else             value = ILAD_VAL_W'($urandom());
    pos = ILAD_POS_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) :
                                                    $urandom_range(0, 15));
    send_item(op, value, pos);
    if (op <= OP_MAX) counted++;
  endtask

  initial begin
    int counted;
    int phase;
    rst_ni      = 1'b0;
    push        = 1'b0;
    op_i        = OP_APPEND;
    new_value_i = '0;
    position_i  = '0;
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_item(OP_PRINT, '0, '0);
    send_item(OP_PRINT_REV, '0, '0);
    send_item(OP_MAX, '0, '0);
    send_item(OP_DELETE, '0, '0);
    send_item(OP_DELETE, '0, {ILAD_POS_W{1'b1}});
    send_item(OP_APPEND, {ILAD_VAL_W{1'b1}}, '0);
    send_item(OP_APPEND, '0, {ILAD_POS_W{1'b1}});
    send_item(OP_APPEND, 31'h2AAA_AAAA, '0);
    send_item(OP_APPEND, 31'h5555_5555, '0);
    send_item(OP_APPEND, 31'd1, '0);
    send_item(OP_PRINT, '0, '0);
    send_item(OP_PRINT_REV, '0, '0);
    send_item(OP_MAX, '0, '0);
    send_item(OP_DELETE, '0, 4'd4);
    send_item(OP_DELETE, '0, 4'd0);
    send_item(OP_DELETE, '0, 4'd1);
    send_item(OP_DELETE, '0, 4'd2);
    send_item(OP_DELETE, '0, {ILAD_POS_W{1'b1}});
    for (int c = OP_MAX + 1; c < 2 ** ILAD_OP_W; c++) begin
      send_item(ILAD_OP_W'(c), {ILAD_VAL_W{1'b1}}, '1);
    end
    send_item(OP_MAX, '0, '0);
    send_item(OP_PRINT, '0, '0);
    drain_results();

    counted = 0;
    phase   = 0;
    while (counted < RANDOM_ITEMS) begin
      calm = (phase % 4 == 3);
      if (phase == 3) begin
        calm        = 1'b1;
        rx_hold_req = 1'b1;
        for (int k = 0; k < 16; k++) send_random_item(0, counted);
        calm = 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS && counted < RANDOM_ITEMS; k++) begin
        send_random_item(phase % 3, counted);
      end
      if (phase == 5) drain_results();
      phase++;
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
